### sv/ogbd_pkg.sv
`default_nettype none
package ogbd_pkg;

    localparam int ID_COUNT_DEFAULT   = 64;
    localparam int POOL_DEPTH_DEFAULT = 16;

    localparam logic CMD_ARRIVAL   = 1'b0;
    localparam logic CMD_COST_LOAD = 1'b1;
    localparam logic SIDE_TASK     = 1'b0;
    localparam logic SIDE_WORKER   = 1'b1;

    localparam logic [1:0] REG_DELTA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_GAMMA = 2'd2;

    localparam logic [15:0] WEIGHT_RESET = 16'd256;

    typedef struct packed {
        logic        command;
        logic        side;
        logic [5:0]  node_id;
        logic [5:0]  other_id;
        logic [15:0] arrival_time;
        logic [15:0] deadline;
        logic [15:0] cost_value;
        logic        cost_feasible;
    } in_t;

    typedef struct packed {
        logic        matched;
        logic [5:0]  partner_id;
        logic [31:0] match_weight;
        logic [31:0] bottleneck;
        logic [5:0]  bottleneck_task_id;
        logic [5:0]  bottleneck_worker_id;
        logic [5:0]  expired_count;
        logic        pool_full;
    } out_t;

    typedef struct packed {
        logic [5:0]  id;
        logic [15:0] arr;
        logic [15:0] dl;
    } waiter_t;

    typedef struct packed {
        logic [15:0] delta;
        logic [15:0] beta;
        logic [15:0] gamma;
    } weights_t;

    // Handshake between the front queue and the engine.
    typedef struct packed {
        logic valid;
        in_t  item;
    } cmd_t;

endpackage
`default_nettype wire

### sv/ogbd_front.sv
`default_nettype none
module ogbd_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire ogbd_pkg::in_t item,
    output ogbd_pkg::cmd_t     cmd,
    input  wire logic          take
);

    // Two-entry queue that decouples the input side from the engine.
    ogbd_pkg::in_t slot_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    count_reg;

    logic do_push;
    logic do_take;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_take = take && (count_reg != 2'd0);

    assign cmd.valid = (count_reg != 2'd0);
    assign cmd.item  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_take)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_take);
        end
    end

endmodule
`default_nettype wire

### sv/ogbd_engine.sv
`default_nettype none
module ogbd_engine
#(
    parameter int ID_COUNT   = ogbd_pkg::ID_COUNT_DEFAULT,
    parameter int POOL_DEPTH = ogbd_pkg::POOL_DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ogbd_pkg::cmd_t     cmd,
    output logic                    take,
    input  wire ogbd_pkg::weights_t weights,
    output logic                    res_valid,
    output ogbd_pkg::out_t          res,
    input  wire logic               res_ready
);

    localparam int IDN = (ID_COUNT < 64) ? ID_COUNT : 64;
    localparam int MD  = IDN * IDN;
    localparam int AW  = $clog2(MD);
    localparam int PD  = POOL_DEPTH;
    localparam int PW  = (PD > 1) ? $clog2(PD) : 1;
    localparam int CW  = $clog2(PD + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PACK  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PACK2 = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;

    logic [16:0] cost_mem [MD];
    logic [16:0] cost_q_reg;

    ogbd_pkg::waiter_t task_pool_reg   [PD];
    ogbd_pkg::waiter_t worker_pool_reg [PD];
    logic [PD-1:0]     task_valid_reg;
    logic [PD-1:0]     worker_valid_reg;

    ogbd_pkg::in_t cur_reg;
    logic [5:0]    expired_reg;
    logic [31:0]   bn_value_reg;
    logic [5:0]    bn_task_reg;
    logic [5:0]    bn_worker_reg;

    logic [CW-1:0] issue_reg;
    logic          s0_valid_reg;
    logic [PW-1:0] s0_k_reg;
    logic          s0_oor_reg;
    logic [15:0]   s0_wait_reg;
    logic          s1_valid_reg;
    logic [PW-1:0] s1_k_reg;
    logic          s1_feas_reg;
    logic [31:0]   pd_reg;
    logic [31:0]   pb_reg;
    logic [31:0]   pg_reg;
    logic          found_reg;
    logic [31:0]   best_w_reg;
    logic [PW-1:0] best_k_reg;

    logic [CW-1:0] n_task;
    logic [CW-1:0] n_worker;
    logic [CW-1:0] n_own;
    logic [CW-1:0] n_opp;
    logic          compact;
    logic [PD-1:0] task_exp;
    logic [PD-1:0] worker_exp;
    logic [PD-1:0] task_shift;
    logic [PD-1:0] worker_shift;

    ogbd_pkg::waiter_t opp_entry;
    logic [5:0]        t_id;
    logic [5:0]        w_id;
    logic              pair_oor;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              load_ok;
    logic              issue;
    logic              scan_done;
    logic [33:0]       wsum;
    logic [31:0]       wsat;

    assign n_task   = CW'($countones(task_valid_reg));
    assign n_worker = CW'($countones(worker_valid_reg));
    assign n_own    = cur_reg.side ? n_worker : n_task;
    assign n_opp    = cur_reg.side ? n_task : n_worker;
    // A pool is in order when its valid bits form one run from the bottom.
    assign compact  = ((task_valid_reg & (task_valid_reg + PD'(1))) == '0)
                   && ((worker_valid_reg & (worker_valid_reg + PD'(1))) == '0);

    always_comb
    begin
        for (int i = 0; i < PD; i++)
        begin
            task_exp[i]     = task_valid_reg[i] && (task_pool_reg[i].dl < cmd.item.arrival_time);
            worker_exp[i]   = worker_valid_reg[i]
                           && (worker_pool_reg[i].dl < cmd.item.arrival_time);
            task_shift[i]   = ((~task_valid_reg) & PD'((64'd2 << i) - 64'd1)) != '0;
            worker_shift[i] = ((~worker_valid_reg) & PD'((64'd2 << i) - 64'd1)) != '0;
        end
    end

    assign opp_entry = cur_reg.side ? task_pool_reg[issue_reg[PW-1:0]]
                                    : worker_pool_reg[issue_reg[PW-1:0]];
    assign t_id      = cur_reg.side ? opp_entry.id : cur_reg.node_id;
    assign w_id      = cur_reg.side ? cur_reg.node_id : opp_entry.id;
    assign pair_oor  = (int'(t_id) >= IDN) || (int'(w_id) >= IDN);
    assign rd_addr   = AW'(int'(t_id) * IDN + int'(w_id));
    assign wr_addr   = AW'(int'(cmd.item.node_id) * IDN + int'(cmd.item.other_id));
    assign load_ok   = (int'(cmd.item.node_id) < IDN) && (int'(cmd.item.other_id) < IDN);

    assign take      = (state_reg == ST_IDLE) && cmd.valid;
    assign issue     = (state_reg == ST_SCAN) && (issue_reg < n_opp);
    assign scan_done = (state_reg == ST_SCAN) && (issue_reg == n_opp)
                    && !s0_valid_reg && !s1_valid_reg;

    assign wsum = {2'b00, pd_reg} + {2'b00, pb_reg} + {2'b00, pg_reg};
    assign wsat = (wsum[33:32] != 2'b00) ? 32'hFFFF_FFFF : wsum[31:0];

    assign res_valid = (state_reg == ST_DONE);

    always_ff @(posedge clk)
    begin
        if (take && (cmd.item.command == ogbd_pkg::CMD_COST_LOAD) && load_ok)
        begin
            cost_mem[wr_addr] <= {cmd.item.cost_feasible, cmd.item.cost_value};
        end
        cost_q_reg <= cost_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg     <= cmd.item;
            expired_reg <= 6'($countones(task_exp) + $countones(worker_exp));
        end
        if (issue)
        begin
            s0_k_reg    <= issue_reg[PW-1:0];
            s0_oor_reg  <= pair_oor;
            s0_wait_reg <= (cur_reg.arrival_time >= opp_entry.arr)
                         ? (cur_reg.arrival_time - opp_entry.arr) : 16'd0;
        end
        s1_k_reg    <= s0_k_reg;
        s1_feas_reg <= cost_q_reg[16] && !s0_oor_reg;
        pd_reg      <= weights.delta * cost_q_reg[15:0];
        pb_reg      <= cur_reg.side ? weights.beta * s0_wait_reg : 32'd0;
        pg_reg      <= cur_reg.side ? 32'd0 : weights.gamma * s0_wait_reg;
        if ((state_reg == ST_PACK) || (state_reg == ST_PACK2))
        begin
            for (int i = 0; i < PD; i++)
            begin
                if (task_shift[i] && (i + 1 < PD))
                begin
                    task_pool_reg[i] <= task_pool_reg[(i + 1) % PD];
                end
                if (worker_shift[i] && (i + 1 < PD))
                begin
                    worker_pool_reg[i] <= worker_pool_reg[(i + 1) % PD];
                end
            end
        end
        if (scan_done && !found_reg && (n_own < CW'(PD)))
        begin
            if (cur_reg.side)
            begin
                worker_pool_reg[n_own[PW-1:0]] <= '{cur_reg.node_id,
                                                    cur_reg.arrival_time, cur_reg.deadline};
            end
            else
            begin
                task_pool_reg[n_own[PW-1:0]] <= '{cur_reg.node_id,
                                                  cur_reg.arrival_time, cur_reg.deadline};
            end
        end
        if (scan_done)
        begin
            res.matched              <= found_reg;
            res.partner_id           <= found_reg ? (cur_reg.side ? task_pool_reg[best_k_reg].id
                                                   : worker_pool_reg[best_k_reg].id) : 6'd0;
            res.match_weight         <= found_reg ? best_w_reg : 32'd0;
            res.expired_count        <= expired_reg;
            res.pool_full            <= !found_reg && (n_own >= CW'(PD));
        end
        else if (take && (cmd.item.command == ogbd_pkg::CMD_COST_LOAD))
        begin
            res.matched       <= 1'b0;
            res.partner_id    <= 6'd0;
            res.match_weight  <= 32'd0;
            res.expired_count <= 6'd0;
            res.pool_full     <= 1'b0;
        end
        // The bottleneck fields follow the stored pair until the result is
        // settled, and then hold while the beat waits.
        if (scan_done && found_reg && (best_w_reg >= bn_value_reg))
        begin
            res.bottleneck           <= best_w_reg;
            res.bottleneck_task_id   <= cur_reg.side ? task_pool_reg[best_k_reg].id
                                                     : cur_reg.node_id;
            res.bottleneck_worker_id <= cur_reg.side ? cur_reg.node_id
                                                     : worker_pool_reg[best_k_reg].id;
        end
        else if ((state_reg == ST_SCAN) || (state_reg == ST_IDLE))
        begin
            res.bottleneck           <= bn_value_reg;
            res.bottleneck_task_id   <= bn_task_reg;
            res.bottleneck_worker_id <= bn_worker_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            task_valid_reg   <= '0;
            worker_valid_reg <= '0;
            bn_value_reg     <= 32'd0;
            bn_task_reg      <= 6'd0;
            bn_worker_reg    <= 6'd0;
            issue_reg        <= '0;
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            best_w_reg       <= 32'd0;
            best_k_reg       <= '0;
        end
        else
        begin
            s0_valid_reg <= issue;
            s1_valid_reg <= s0_valid_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        if (cmd.item.command == ogbd_pkg::CMD_COST_LOAD)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            task_valid_reg   <= task_valid_reg & ~task_exp;
                            worker_valid_reg <= worker_valid_reg & ~worker_exp;
                            state_reg        <= ST_PACK;
                        end
                    end
                end
                ST_PACK, ST_PACK2:
                begin
                    if (compact)
                    begin
                        state_reg <= (state_reg == ST_PACK) ? ST_SCAN : ST_DONE;
                        issue_reg <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        for (int i = 0; i < PD; i++)
                        begin
                            if (task_shift[i])
                            begin
                                task_valid_reg[i] <= (i + 1 < PD)
                                                   ? task_valid_reg[(i + 1) % PD] : 1'b0;
                            end
                            if (worker_shift[i])
                            begin
                                worker_valid_reg[i] <= (i + 1 < PD)
                                                     ? worker_valid_reg[(i + 1) % PD] : 1'b0;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        issue_reg <= issue_reg + CW'(1);
                    end
                    if (s1_valid_reg && s1_feas_reg && (!found_reg || (wsat < best_w_reg)))
                    begin
                        found_reg  <= 1'b1;
                        best_w_reg <= wsat;
                        best_k_reg <= s1_k_reg;
                    end
                    if (scan_done)
                    begin
                        if (found_reg)
                        begin
                            if (cur_reg.side)
                            begin
                                task_valid_reg[best_k_reg] <= 1'b0;
                            end
                            else
                            begin
                                worker_valid_reg[best_k_reg] <= 1'b0;
                            end
                            if (best_w_reg >= bn_value_reg)
                            begin
                                bn_value_reg  <= best_w_reg;
                                bn_task_reg   <= cur_reg.side ? task_pool_reg[best_k_reg].id
                                                              : cur_reg.node_id;
                                bn_worker_reg <= cur_reg.side ? cur_reg.node_id
                                                              : worker_pool_reg[best_k_reg].id;
                            end
                            state_reg <= ST_PACK2;
                        end
                        else
                        begin
                            if (n_own < CW'(PD))
                            begin
                                if (cur_reg.side)
                                begin
                                    worker_valid_reg[n_own[PW-1:0]] <= 1'b1;
                                end
                                else
                                begin
                                    task_valid_reg[n_own[PW-1:0]] <= 1'b1;
                                end
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sv/online_greedy_bipartite_dispatch.sv
// A cost load is written to the cost table (when its ids are in range) as the engine takes
// it, and then goes on to the result queue. An arrival waits in the input queue, drops
// expired waiters when it is taken, compacts the pools, scans the opposite waiters,
// compacts the pools again after a match, and then passes its result into the result queue.
// Throughput is one item at a time, set by the single engine's scan and packing.
// Reset clears both pools, the bottleneck and the queues; the cost table is not.
`default_nettype none
module online_greedy_bipartite_dispatch
#(
    parameter int ID_COUNT   = ogbd_pkg::ID_COUNT_DEFAULT,
    parameter int POOL_DEPTH = ogbd_pkg::POOL_DEPTH_DEFAULT
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire ogbd_pkg::in_t item,
    output logic               empty,
    input  wire logic          pop,
    output ogbd_pkg::out_t     result,
    input  wire logic          wr_en,
    input  wire logic [1:0]    wr_index,
    input  wire logic [15:0]   wr_data
);

    // Weight factors; the user must write them only while the block is idle, which the block itself does not enforce.
    ogbd_pkg::weights_t weights_reg;

    ogbd_pkg::cmd_t cmd;
    logic           take;
    logic           res_valid;
    logic           res_ready;
    ogbd_pkg::out_t res;

    // Result queue of two beats, so the engine can finish while the
    // consumer stalls.
    ogbd_pkg::out_t rq_reg [2];
    logic           rq_wptr_reg;
    logic           rq_rptr_reg;
    logic [1:0]     rq_count_reg;
    logic           rq_push;
    logic           rq_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg <= '{ogbd_pkg::WEIGHT_RESET, ogbd_pkg::WEIGHT_RESET,
                             ogbd_pkg::WEIGHT_RESET};
        end
        else if (wr_en)
        begin
            priority case (wr_index)
                ogbd_pkg::REG_DELTA: weights_reg.delta <= wr_data;
                ogbd_pkg::REG_BETA:  weights_reg.beta  <= wr_data;
                ogbd_pkg::REG_GAMMA: weights_reg.gamma <= wr_data;
                default:             weights_reg       <= weights_reg;
            endcase
        end
    end

    ogbd_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .cmd   (cmd),
        .take  (take)
    );

    ogbd_engine
    #(
        .ID_COUNT   (ID_COUNT),
        .POOL_DEPTH (POOL_DEPTH)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .take      (take),
        .weights   (weights_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = (rq_count_reg != 2'd2);
    assign rq_push   = res_valid && res_ready;
    assign empty     = (rq_count_reg == 2'd0);
    assign rq_pop    = pop && !empty;
    assign result    = rq_reg[rq_rptr_reg];

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_wptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wptr_reg  <= 1'b0;
            rq_rptr_reg  <= 1'b0;
            rq_count_reg <= 2'd0;
        end
        else
        begin
            if (rq_push)
            begin
                rq_wptr_reg <= !rq_wptr_reg;
            end
            if (rq_pop)
            begin
                rq_rptr_reg <= !rq_rptr_reg;
            end
            rq_count_reg <= rq_count_reg + 2'(rq_push) - 2'(rq_pop);
        end
    end

endmodule
`default_nettype wire
